// ===== src/srlt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package srlt_pkg;
    localparam int TableDepth = 64;
    localparam int MaxPath = 16;
    localparam int TIdxW = $clog2(TableDepth);
    localparam int TCntW = $clog2(TableDepth + 1);
    localparam int PIdxW = $clog2(MaxPath);
    localparam int PCntW = $clog2(MaxPath + 1);
    localparam int AddrW = 48;

    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StFull = 2'd1;
    localparam logic [1:0] StLong = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LK_RD,
        S_LK_CMP,
        S_SC_RD,
        S_SC_CMP,
        S_FW_RD,
        S_FW_DO,
        S_BW_RD,
        S_BW_DO,
        S_OUT
    } t_state;

    typedef struct packed {
        logic          kind;
        logic          found;
        logic [47:0]   next_hop;
        logic [6:0]    added;
        logic [1:0]    status;
    } t_result;
endpackage
`default_nettype wire

// ===== src/srlt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module srlt_ram #(
    parameter int Width = 48,
    parameter int Depth = 64
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(Depth)-1:0]   i_waddr,
    input  wire [Width-1:0]           i_wdata,
    input  wire [$clog2(Depth)-1:0]   i_raddr,
    output logic [Width-1:0]          o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/source_route_learning_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Content
// s_axis    in   tdata: address[47:0]; tuser: action; tlast: path_end
// m_axis    out  tdata: next_hop[47:0], added[54:48], status[56:55] (64b); tuser: kind, found
// cfg       in   own_address, 48 bits
// A lookup scans the route table one entry at a time (read, then compare).
// A path end scans the buffer and, if the own address is in it, walks forward and backward.
// Reset is synchronous and clears counters and the machine; memories are not cleared.
// Input is taken only in idle; a held result blocks the next item until taken.
module source_route_learning_table (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [47:0]  s_axis_tdata,   // address
    input  wire         s_axis_tuser,   // action
    input  wire         s_axis_tlast,   // path_end
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // next_hop, added, status, zero fill
    output logic [1:0]  m_axis_tuser,   // kind, found
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [47:0]  i_cfg_data
);
    import srlt_pkg::*;

    t_state r_state, n_state;
    logic [47:0] r_own;
    logic [TCntW-1:0] r_count, n_count;
    logic [PCntW-1:0] r_plen, n_plen;
    logic r_ovf, n_ovf;
    logic [47:0] r_key, n_key;
    logic [TCntW-1:0] r_ti, n_ti;
    logic [PCntW-1:0] r_pi, n_pi;
    logic [PIdxW-1:0] r_first, n_first, r_lastp, n_lastp;
    logic r_hasown, n_hasown;
    logic r_seek, n_seek;
    logic [47:0] r_nb, n_nb;
    logic [6:0] r_added, n_added;
    logic r_drop, n_drop;
    logic r_oval, n_oval;
    t_result r_res, n_res;

    logic t_we;
    logic [TIdxW-1:0] t_ra;
    logic [47:0] t_wd, t_wn, t_dest, t_next;
    logic p_we;
    logic [PIdxW-1:0] p_wa, p_ra;
    logic [47:0] p_rd;

    srlt_ram #(.Width(AddrW), .Depth(TableDepth)) u_dest (
        .i_clk, .i_we(t_we), .i_waddr(r_count[TIdxW-1:0]), .i_wdata(t_wd),
        .i_raddr(t_ra), .o_rdata(t_dest));
    srlt_ram #(.Width(AddrW), .Depth(TableDepth)) u_next (
        .i_clk, .i_we(t_we), .i_waddr(r_count[TIdxW-1:0]), .i_wdata(t_wn),
        .i_raddr(t_ra), .o_rdata(t_next));
    srlt_ram #(.Width(AddrW), .Depth(MaxPath)) u_path (
        .i_clk, .i_we(p_we), .i_waddr(p_wa), .i_wdata(s_axis_tdata),
        .i_raddr(p_ra), .o_rdata(p_rd));

    assign o_cfg_ready = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE) && !r_oval;
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata = {7'd0, r_res.status, r_res.added, r_res.next_hop};
    assign m_axis_tuser = {r_res.found, r_res.kind};

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_own <= '0;
            r_count <= '0;
            r_plen <= '0;
            r_ovf <= 1'b0;
            r_oval <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_own <= i_cfg_data;
            end
            r_count <= n_count;
            r_plen <= n_plen;
            r_ovf <= n_ovf;
            r_oval <= n_oval;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_ti <= n_ti;
        r_pi <= n_pi;
        r_first <= n_first;
        r_lastp <= n_lastp;
        r_hasown <= n_hasown;
        r_seek <= n_seek;
        r_nb <= n_nb;
        r_added <= n_added;
        r_drop <= n_drop;
        r_res <= n_res;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_plen = r_plen;
        n_ovf = r_ovf;
        n_key = r_key;
        n_ti = r_ti;
        n_pi = r_pi;
        n_first = r_first;
        n_lastp = r_lastp;
        n_hasown = r_hasown;
        n_seek = r_seek;
        n_nb = r_nb;
        n_added = r_added;
        n_drop = r_drop;
        n_oval = r_oval && !m_axis_tready;
        n_res = r_res;
        t_we = 1'b0;
        t_wd = '0;
        t_wn = '0;
        t_ra = r_ti[TIdxW-1:0];
        p_we = 1'b0;
        p_wa = r_plen[PIdxW-1:0];
        p_ra = r_pi[PIdxW-1:0];
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_key = s_axis_tdata;
                    if (s_axis_tuser) begin
                        n_ti = '0;
                        n_state = S_LK_RD;
                    end else begin
                        if (r_plen < PCntW'(MaxPath)) begin
                            p_we = 1'b1;
                            n_plen = r_plen + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                        if (s_axis_tlast) begin
                            n_added = '0;
                            n_drop = 1'b0;
                            n_hasown = 1'b0;
                            n_pi = '0;
                            if (r_plen >= PCntW'(MaxPath)) begin
                                n_res = '{1'b1, 1'b0, 48'd0, 7'd0, StLong};
                                n_state = S_OUT;
                            end else begin
                                n_state = S_SC_RD;
                            end
                        end
                    end
                end
            end
            S_LK_RD: begin
                if (r_ti >= r_count) begin
                    n_res = '{1'b0, 1'b0, 48'd0, 7'd0, StOk};
                    n_state = S_OUT;
                end else begin
                    n_state = S_LK_CMP;
                end
            end
            S_LK_CMP: begin
                if (t_dest == r_key) begin
                    n_res = '{1'b0, 1'b1, t_next, 7'd0, StOk};
                    n_state = S_OUT;
                end else begin
                    n_ti = r_ti + 1'b1;
                    t_ra = n_ti[TIdxW-1:0];
                    n_state = S_LK_RD;
                end
            end
            S_SC_RD: begin
                if (r_pi >= r_plen) begin
                    if (r_hasown) begin
                        n_pi = PCntW'(r_first);
                        n_seek = 1'b1;
                        n_state = S_FW_RD;
                    end else begin
                        n_res = '{1'b1, 1'b0, 48'd0, 7'd0, StOk};
                        n_state = S_OUT;
                    end
                end else begin
                    n_state = S_SC_CMP;
                end
            end
            S_SC_CMP: begin
                if (p_rd == r_own) begin
                    if (!r_hasown) begin
                        n_first = r_pi[PIdxW-1:0];
                    end
                    n_hasown = 1'b1;
                    n_lastp = r_pi[PIdxW-1:0];
                end
                n_pi = r_pi + 1'b1;
                p_ra = n_pi[PIdxW-1:0];
                n_state = S_SC_RD;
            end
            S_FW_RD: begin
                if (r_pi >= r_plen) begin
                    n_pi = PCntW'(r_lastp);
                    n_seek = 1'b1;
                    n_state = S_BW_RD;
                end else begin
                    n_state = S_FW_DO;
                end
            end
            S_FW_DO, S_BW_DO: begin
                if (!r_seek || p_rd != r_own) begin
                    if (r_count < TCntW'(TableDepth)) begin
                        t_we = 1'b1;
                        t_wd = p_rd;
                        t_wn = r_seek ? p_rd : r_nb;
                        n_count = r_count + 1'b1;
                        n_added = r_added + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (r_seek) begin
                        n_nb = p_rd;
                    end
                    n_seek = 1'b0;
                end
                if (r_state == S_FW_DO) begin
                    n_pi = r_pi + 1'b1;
                    n_state = S_FW_RD;
                end else if (r_pi == '0) begin
                    n_res = '{1'b1, 1'b0, 48'd0, n_added, n_drop ? StFull : StOk};
                    n_state = S_OUT;
                end else begin
                    n_pi = r_pi - 1'b1;
                    n_state = S_BW_RD;
                end
                p_ra = n_pi[PIdxW-1:0];
            end
            S_BW_RD: begin
                n_state = S_BW_DO;
            end
            S_OUT: begin
                if (!r_oval || m_axis_tready) begin
                    n_oval = 1'b1;
                    if (n_res.kind) begin
                        n_plen = '0;
                        n_ovf = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef SYNTH
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= TCntW'(TableDepth)) else $error("table count overflow");
    a_plen_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plen <= PCntW'(MaxPath)) else $error("path length overflow");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        t_we |-> (r_state == S_FW_DO || r_state == S_BW_DO)) else $error("stray write");
`endif
endmodule
`default_nettype wire

// ===== bench/route_checker.sv =====
`timescale 1ns / 1ps
module route_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    input  wire [47:0]  s_axis_tdata,   // address
    input  wire         s_axis_tuser,   // action
    input  wire         s_axis_tlast,   // path_end
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire [63:0]  m_axis_tdata,   // next_hop, added, status, zero fill
    input  wire [1:0]   m_axis_tuser,   // kind, found
    input  wire         i_cfg_valid,
    input  wire         o_cfg_ready,
    input  wire [47:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import srlt_pkg::*;

    logic [47:0] my_addr;
    logic [47:0] tbl_dest [TableDepth];
    logic [47:0] tbl_next [TableDepth];
    int          tbl_count;
    logic [47:0] hops [MaxPath];
    int          hop_count;
    bit          hop_overflow;
    int          learned;
    bit          dropped;
    t_result     answers_due [$];

    assign o_pending = answers_due.size();

    // append one expected result at the tail
    function automatic void queue_answer(input t_result r);
        answers_due = {answers_due, r};
    endfunction

    function automatic void store_route(input logic [47:0] dst, input logic [47:0] nh);
        if (tbl_count < TableDepth) begin
            tbl_dest[tbl_count] = dst;
            tbl_next[tbl_count] = nh;
            tbl_count++;
            learned++;
        end else begin
            dropped = 1'b1;
        end
    endfunction

    function automatic void walk_hops(input int start, input int dir);
        bit          seeking;
        logic [47:0] nbr;
        seeking = 1'b1;
        nbr = '0;
        for (int i = start; i >= 0 && i < hop_count; i += dir) begin
            if (seeking) begin
                if (hops[i] != my_addr) begin
                    nbr = hops[i];
                    seeking = 1'b0;
                    store_route(hops[i], hops[i]);
                end
            end else begin
                store_route(hops[i], nbr);
            end
        end
    endfunction

    function automatic t_result route_answer(input logic [47:0] dst);
        t_result r;
        r = '0;
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_dest[i] == dst) begin
                r.found = 1'b1;
                r.next_hop = tbl_next[i];
                break;
            end
        end
        return r;
    endfunction

    function automatic t_result learn_path();
        t_result r;
        int first, lastpos;
        r = '0;
        r.kind = 1'b1;
        learned = 0;
        dropped = 1'b0;
        if (hop_overflow) begin
            r.status = StLong;
        end else begin
            first = -1;
            lastpos = -1;
            for (int i = 0; i < hop_count; i++) begin
                if (hops[i] == my_addr) begin
                    if (first < 0) first = i;
                    lastpos = i;
                end
            end
            if (first >= 0) begin
                walk_hops(first, 1);
                walk_hops(lastpos, -1);
            end
            r.status = dropped ? StFull : StOk;
        end
        r.added = learned[6:0];
        hop_count = 0;
        hop_overflow = 1'b0;
        return r;
    endfunction

    t_result got, want;

    // predict on input transfers, compare on output transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            my_addr <= '0;
            tbl_count = 0;
            hop_count = 0;
            hop_overflow = 1'b0;
            answers_due.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) my_addr <= i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser) begin
                    queue_answer(route_answer(s_axis_tdata));
                end else begin
                    if (hop_count < MaxPath) hops[hop_count++] = s_axis_tdata;
                    else hop_overflow = 1'b1;
                    if (s_axis_tlast) queue_answer(learn_path());
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind = m_axis_tuser[0];
                got.found = m_axis_tuser[1];
                got.next_hop = m_axis_tdata[47:0];
                got.added = m_axis_tdata[54:48];
                got.status = m_axis_tdata[56:55];
                if (answers_due.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = answers_due.pop_front();
                    if (got != want || m_axis_tdata[63:57] != 0) begin
                        if (o_fail_count < 10) begin
                            $write("mismatch: exp k%0d f%0d nh %h add %0d st %0d,",
                                want.kind, want.found, want.next_hop, want.added,
                                want.status);
                            $display(" got k%0d f%0d nh %h add %0d st %0d",
                                got.kind, got.found, got.next_hop, got.added, got.status);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import srlt_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [47:0] i_cfg_data = '0;
    int          fail_count, pending;
    int          idle_cycles;
    int          stall_mode;

    localparam int IdleLimit = 20000;

    always #5 i_clk = ~i_clk;

    source_route_learning_table i_dut (.*);

    route_checker u_checker (.*, .o_fail_count(fail_count), .o_pending(pending));

    // receiver stall pattern, mode changes now and then
    always @(posedge i_clk) begin
        if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    logic [47:0] own;
    int          burst;

    task automatic send_item(input bit act, input logic [47:0] a, input bit last);
        if (burst == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= act;
        s_axis_tdata <= a;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        burst--;
    endtask

    task automatic write_own(input logic [47:0] v);
        s_axis_tvalid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        own = v;
    endtask

    function automatic logic [47:0] rand_mac();
        return {16'($urandom()), $urandom()};
    endfunction

    function automatic bit rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // small address pool so lookups hit and own address repeats
    function automatic logic [47:0] pool_mac();
        case ($urandom_range(0, 5))
            0: return own;
            1: return rand_mac();
            default: return 48'h0A0B_0C0D_0000 | 48'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic send_path(input int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0) send_item(1'b1, pool_mac(), rand_bit());
            send_item(1'b0, pool_mac(), i == len - 1);
        end
    endtask

    initial begin
        burst = 0;
        own = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: lookup on empty table, path without own address, extremes
        send_item(1'b1, 48'h0, 1'b1);
        send_item(1'b1, 48'hFFFF_FFFF_FFFF, 1'b0);
        send_item(1'b0, 48'h1, 1'b0);
        send_item(1'b0, 48'hFFFF_FFFF_FFFF, 1'b1);
        write_own(48'hFFFF_FFFF_FFFF);
        // own three times, repeated own in middle
        send_item(1'b0, 48'h11, 1'b0);
        send_item(1'b0, 48'hFFFF_FFFF_FFFF, 1'b0);
        send_item(1'b0, 48'hFFFF_FFFF_FFFF, 1'b0);
        send_item(1'b0, 48'h22, 1'b0);
        send_item(1'b1, 48'h22, 1'b1);   // lookup mid path, last ignored
        send_item(1'b0, 48'hFFFF_FFFF_FFFF, 1'b0);
        send_item(1'b0, 48'h0, 1'b1);
        send_item(1'b1, 48'h22, 1'b0);
        send_item(1'b1, 48'h0, 1'b0);
        send_item(1'b1, 48'h11, 1'b0);
        // own only
        send_item(1'b0, 48'hFFFF_FFFF_FFFF, 1'b1);
        // too long path
        for (int i = 0; i < MaxPath + 2; i++)
            send_item(1'b0, (i == 3) ? 48'hFFFF_FFFF_FFFF : 48'h5555_5555_5555,
                      i == MaxPath + 1);
        write_own(48'h0);

        // random phases with several own addresses; table fills early
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 1) write_own(48'h0A0B_0C0D_0003);
            if (ph == 2) write_own(rand_mac());
            if (ph == 3) write_own(48'h0A0B_0C0D_0000);
            for (int k = 0; k < 400 / 4; k++) begin
                case ($urandom_range(0, 9))
                    0: send_item(rand_bit(), rand_mac(), rand_bit());
                    1, 2, 3: send_item(1'b1, pool_mac(), rand_bit());
                    4: send_path($urandom_range(MaxPath + 1, MaxPath + 3));
                    default: send_path($urandom_range(1, 6));
                endcase
            end
        end
        s_axis_tvalid <= 0;

        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
